### hw/rtl/qte_pkg.sv
// Shared types and constants for the quaternion to Euler angle pipeline.
package qte_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned CORDIC_STEPS_MAX = 24;
  localparam int unsigned SQRT_STAGES      = 31;
  localparam int unsigned FRONT_STAGES     = 3;

  localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;
  localparam logic signed [34:0] PI_Q30   = 35'sd3373259426;
  localparam logic signed [15:0] PI_Q13   = 16'sd25736;
  localparam logic signed [15:0] HPI_Q13  = 16'sd12868;

  // atan(2^-i) in Q.30
  localparam logic [29:0] ATAN_TAB [0:CORDIC_STEPS_MAX-1] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
    30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
    30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
    30'd262144,    30'd131072,    30'd65536,     30'd32768,
    30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128
  };

  typedef struct packed {
    logic signed [33:0] rn;
    logic signed [33:0] rd;
    logic signed [33:0] yn;
    logic signed [33:0] yd;
    logic signed [31:0] pn;
    logic               sat;
  } args_t;

  typedef struct packed {
    logic signed [35:0] x;
    logic signed [35:0] y;
    logic signed [34:0] z;
    logic               zero;
  } cordic_t;

  typedef struct packed {
    cordic_t roll;
    cordic_t pitch;
    cordic_t yaw;
    logic    sat;
  } ang_t;

endpackage

### hw/rtl/qte_front.sv
// Products, argument forming with pitch clamp, and the square root operand.
module qte_front import qte_pkg::*; (
  input  logic               clk_i,
  input  logic [2:0]         en_i,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output args_t              args_o,
  output logic [61:0]        rem_o
);

  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, wy_q, xz_q, wz_q, xy_q, ww_q;
  args_t              args_d, args_q, args_c_q;
  logic signed [33:0] pn_raw;
  logic signed [63:0] pn_sq;
  logic [61:0]        rem_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      wx_q <= quat_w_i * quat_x_i;
      yz_q <= quat_y_i * quat_z_i;
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      wy_q <= quat_w_i * quat_y_i;
      xz_q <= quat_x_i * quat_z_i;
      wz_q <= quat_w_i * quat_z_i;
      xy_q <= quat_x_i * quat_y_i;
      ww_q <= quat_w_i * quat_w_i;
    end
  end

  always_comb begin
    args_d.rn  = (34'(wx_q) + 34'(yz_q)) <<< 1;
    args_d.rd  = ONE_Q30 - ((34'(xx_q) + 34'(yy_q)) <<< 1);
    args_d.yn  = (34'(wz_q) + 34'(xy_q)) <<< 1;
    args_d.yd  = ((34'(ww_q) + 34'(xx_q)) <<< 1) - ONE_Q30;
    pn_raw     = (34'(wy_q) - 34'(xz_q)) <<< 1;
    args_d.sat = 1'b0;
    args_d.pn  = 32'(pn_raw);
    if (pn_raw > ONE_Q30) begin
      args_d.pn  = 32'(ONE_Q30);
      args_d.sat = 1'b1;
    end else if (pn_raw < -ONE_Q30) begin
      args_d.pn  = -32'(ONE_Q30);
      args_d.sat = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      args_q <= args_d;
    end
  end

  assign pn_sq = args_q.pn * args_q.pn;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      args_c_q <= args_q;
      rem_q    <= (62'(1) << 60) - pn_sq[61:0];
    end
  end

  assign args_o = args_c_q;
  assign rem_o  = rem_q;

endmodule

### hw/rtl/qte_sqrt_stage.sv
// One digit step of the integer square root, arguments carried alongside.
module qte_sqrt_stage import qte_pkg::*; #(
  parameter int unsigned K = 0
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  args_t       args_i,
  input  logic [61:0] rem_i,
  input  logic [61:0] root_i,
  output args_t       args_o,
  output logic [61:0] rem_o,
  output logic [61:0] root_o
);

  localparam logic [61:0] BitVal = 62'(1) << (2 * K);

  logic [61:0] trial, rem_d, root_d, rem_q, root_q;
  args_t       args_q;

  always_comb begin
    trial = root_i + BitVal;
    if (rem_i >= trial) begin
      rem_d  = rem_i - trial;
      root_d = (root_i >> 1) + BitVal;
    end else begin
      rem_d  = rem_i;
      root_d = root_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      args_q <= args_i;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign args_o = args_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

### hw/rtl/qte_prep.sv
// Quadrant fold and zero detect ahead of the three vectoring units.
module qte_prep import qte_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  args_t       args_i,
  input  logic [61:0] root_i,
  output ang_t        ang_o
);

  ang_t ang_d, ang_q;

  function automatic cordic_t fold(logic signed [35:0] y, logic signed [35:0] x);
    cordic_t c;
    c.zero = (x == '0) && (y == '0);
    c.x    = x;
    c.y    = y;
    c.z    = '0;
    if (x[35]) begin
      c.x = -x;
      c.y = -y;
      c.z = y[35] ? -PI_Q30 : PI_Q30;
    end
    return c;
  endfunction

  always_comb begin
    ang_d.roll  = fold(36'(args_i.rn), 36'(args_i.rd));
    ang_d.pitch = fold(36'(args_i.pn), 36'(root_i[31:0]));
    ang_d.yaw   = fold(36'(args_i.yn), 36'(args_i.yd));
    ang_d.sat   = args_i.sat;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q <= ang_d;
    end
  end

  assign ang_o = ang_q;

endmodule

### hw/rtl/qte_cordic_stage.sv
// One vectoring CORDIC rotation for roll, pitch and yaw in parallel.
module qte_cordic_stage import qte_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic clk_i,
  input  logic en_i,
  input  ang_t ang_i,
  output ang_t ang_o
);

  localparam logic signed [34:0] AtanVal = 35'(ATAN_TAB[STEP]);

  ang_t ang_d, ang_q;

  function automatic cordic_t rotate(cordic_t c);
    cordic_t r;
    r = c;
    if (!c.y[35]) begin
      r.x = c.x + ($signed(c.y) >>> STEP);
      r.y = c.y - ($signed(c.x) >>> STEP);
      r.z = c.z + AtanVal;
    end else begin
      r.x = c.x - ($signed(c.y) >>> STEP);
      r.y = c.y + ($signed(c.x) >>> STEP);
      r.z = c.z - AtanVal;
    end
    return r;
  endfunction

  always_comb begin
    ang_d.roll  = rotate(ang_i.roll);
    ang_d.pitch = rotate(ang_i.pitch);
    ang_d.yaw   = rotate(ang_i.yaw);
    ang_d.sat   = ang_i.sat;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q <= ang_d;
    end
  end

  assign ang_o = ang_q;

endmodule

### hw/rtl/quaternion_to_euler_core.sv
// Top level: quaternion to roll, pitch and yaw, fully pipelined.
//
// Input channel: in_valid_i / in_ready_o with a Q1.15 quaternion (w, x, y, z).
// Output channel: out_valid_o / out_ready_i with roll and yaw in Q3.13 and
// pitch in Q2.13 radians, and a flag that the pitch sine was clamped to unity.
// Every input transfer gives exactly one output transfer, in order.
// The stages are the product, argument and squaring registers, one per bit
// of the 31-bit square root, one fold stage, one per CORDIC rotation and one
// output register.
// Throughput is one quaternion per cycle while out_ready_i stays high; the
// square root and the CORDIC chains are unrolled, one register stage per step.
// Each stage has a valid bit; a stage takes a new item when it is empty or
// its successor moves, so a stalled receiver fills bubbles before
// in_ready_o drops and nothing is lost or repeated.
// Reset clears all valid bits; the pipeline is empty afterward.
module quaternion_to_euler_core import qte_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [14:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o,
  output logic               pitch_saturated_o
);

  localparam int unsigned PrepIdx = FRONT_STAGES + SQRT_STAGES;
  localparam int unsigned CordIdx = PrepIdx + 1;
  localparam int unsigned OutIdx  = CordIdx + CORDIC_STEPS;
  localparam int unsigned NumStg  = OutIdx + 1;

  logic [NumStg-1:0] v_q;
  logic [NumStg:0]   rdy;

  args_t       sq_args [0:SQRT_STAGES];
  logic [61:0] sq_rem  [0:SQRT_STAGES];
  logic [61:0] sq_root [0:SQRT_STAGES];
  ang_t        cd      [0:CORDIC_STEPS];

  logic signed [15:0] roll_d, yaw_d, pitch_d;
  logic signed [15:0] roll_q, yaw_q;
  logic signed [14:0] pitch_q;
  logic               sat_q;

  // ready ripples back from the receiver; an empty stage is always ready
  assign rdy[NumStg] = out_ready_i;
  for (genvar s = 0; s < NumStg; s++) begin : g_rdy
    assign rdy[s] = !v_q[s] || rdy[s+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int unsigned s = 1; s < NumStg; s++) begin
        if (rdy[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[OutIdx];

  qte_front u_front (
    .clk_i    (clk_i),
    .en_i     (rdy[FRONT_STAGES-1:0]),
    .quat_w_i (quat_w_i),
    .quat_x_i (quat_x_i),
    .quat_y_i (quat_y_i),
    .quat_z_i (quat_z_i),
    .args_o   (sq_args[0]),
    .rem_o    (sq_rem[0])
  );

  assign sq_root[0] = '0;

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
    qte_sqrt_stage #(
      .K (SQRT_STAGES - 1 - j)
    ) u_sqrt (
      .clk_i  (clk_i),
      .en_i   (rdy[FRONT_STAGES+j]),
      .args_i (sq_args[j]),
      .rem_i  (sq_rem[j]),
      .root_i (sq_root[j]),
      .args_o (sq_args[j+1]),
      .rem_o  (sq_rem[j+1]),
      .root_o (sq_root[j+1])
    );
  end

  qte_prep u_prep (
    .clk_i  (clk_i),
    .en_i   (rdy[PrepIdx]),
    .args_i (sq_args[SQRT_STAGES]),
    .root_i (sq_root[SQRT_STAGES]),
    .ang_o  (cd[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    qte_cordic_stage #(
      .STEP (i)
    ) u_cordic (
      .clk_i (clk_i),
      .en_i  (rdy[CordIdx+i]),
      .ang_i (cd[i]),
      .ang_o (cd[i+1])
    );
  end

  // round half up from Q.30 to Q3.13, then clamp to the angle range; a zero vector gives 0
  function automatic logic signed [15:0] to_q13(cordic_t c, logic signed [15:0] lim);
    logic signed [35:0] rnd;
    logic signed [35:0] lim_w;
    logic signed [15:0] r;
    rnd   = (36'(c.z) + 36'sd65536) >>> 17;
    lim_w = 36'(lim);
    if (c.zero) begin
      r = '0;
    end else if (rnd > lim_w) begin
      r = lim;
    end else if (rnd < -lim_w) begin
      r = -lim;
    end else begin
      r = 16'(rnd);
    end
    return r;
  endfunction

  always_comb begin
    roll_d  = to_q13(cd[CORDIC_STEPS].roll, PI_Q13);
    pitch_d = to_q13(cd[CORDIC_STEPS].pitch, HPI_Q13);
    yaw_d   = to_q13(cd[CORDIC_STEPS].yaw, PI_Q13);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[OutIdx]) begin
      roll_q  <= roll_d;
      pitch_q <= pitch_d[14:0];
      yaw_q   <= yaw_d;
      sat_q   <= cd[CORDIC_STEPS].sat;
    end
  end

  assign roll_angle_o      = roll_q;
  assign pitch_angle_o     = pitch_q;
  assign yaw_angle_o       = yaw_q;
  assign pitch_saturated_o = sat_q;

endmodule

### tb/tb_quaternion_to_euler_core.sv
// Self-checking testbench for the quaternion to Euler angle core.
module tb_quaternion_to_euler_core;
  import qte_pkg::*;

  localparam int unsigned STEPS     = CORDIC_STEPS_DEF;
  localparam int unsigned LATENCY   = 36 + STEPS;
  localparam int unsigned N_RANDOM  = 850;
  localparam longint      CYCLE_MAX = 400000;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               sat;
  } euler_t;

  typedef struct {
    logic signed [15:0] w, x, y, z;
    bit                 typed;   // expected angles given in the row
    euler_t             ang;
  } quat_row_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [15:0] roll_o, yaw_o;
  logic signed [14:0] pitch_o;
  logic               sat_o;

  euler_t expected_angles[$];
  int     n_errors;
  longint cycle_cnt;
  int     send_idle_pct, recv_idle_pct;

  quaternion_to_euler_core #(.CORDIC_STEPS(STEPS)) i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .quat_w_i(qw), .quat_x_i(qx), .quat_y_i(qy), .quat_z_i(qz),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .roll_angle_o(roll_o), .pitch_angle_o(pitch_o),
    .yaw_angle_o(yaw_o), .pitch_saturated_o(sat_o)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic longint shr_floor(longint v, int unsigned s);
    if (s >= 63) return (v < 0) ? -1 : 0;
    return v >>> s;
  endfunction

  function automatic longint arctan_step(int unsigned i);
    longint unsigned acc, term, sh;
    if (i == 0) return 64'd843314857;
    acc = 0;
    for (int unsigned k = 0; k < 32; k++) begin
      sh = longint'(i) * (2 * k + 1);
      if (sh > 62) break;
      term = ((64'd1 << 62) >> sh) / (2 * k + 1);
      if (k & 1) acc -= term;
      else acc += term;
    end
    return longint'((acc + (64'd1 << 31)) >> 32);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint vector_angle(longint yv, longint xv);
    longint base, acc, dx, dy;
    base = 0;
    acc = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      base = (yv >= 0) ? 64'sd3373259426 : -64'sd3373259426;
      xv = -xv;
      yv = -yv;
    end
    for (int unsigned i = 0; i < STEPS; i++) begin
      dx = shr_floor(yv, i);
      dy = shr_floor(xv, i);
      if (yv >= 0) begin
        xv += dx; yv -= dy; acc += arctan_step(i);
      end else begin
        xv -= dx; yv += dy; acc -= arctan_step(i);
      end
    end
    return base + acc;
  endfunction

  function automatic longint q30_to_q13(longint a, longint lim);
    longint r;
    r = shr_floor(a + 65536, 17);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic euler_t predict_euler(logic signed [15:0] w, x, y, z);
    euler_t e;
    longint lw, lx, ly, lz, rn, rd, pn, yn, yd, c;
    lw = w; lx = x; ly = y; lz = z;
    rn = 2 * (lw * lx + ly * lz);
    rd = 64'sd1073741824 - 2 * (lx * lx + ly * ly);
    pn = 2 * (lw * ly - lx * lz);
    yn = 2 * (lw * lz + lx * ly);
    yd = 2 * (lw * lw + lx * lx) - 64'sd1073741824;
    e.sat = 1'b0;
    if (pn > 64'sd1073741824) begin
      pn = 64'sd1073741824; e.sat = 1'b1;
    end else if (pn < -64'sd1073741824) begin
      pn = -64'sd1073741824; e.sat = 1'b1;
    end
    c = longint'(int_sqrt((64'd1 << 60) - longint'(pn * pn)));
    e.roll  = 16'(q30_to_q13(vector_angle(rn, rd), 25736));
    e.pitch = 15'(q30_to_q13(vector_angle(pn, c), 12868));
    e.yaw   = 16'(q30_to_q13(vector_angle(yn, yd), 25736));
    return e;
  endfunction

  // ---------------- checking ----------------
  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_cnt);
    n_errors++;
  endtask

  always @(posedge clk) begin
    euler_t e;
    if (rst_n) begin
      cycle_cnt <= cycle_cnt + 1;
      if (out_valid && out_ready) begin
        if (expected_angles.size() == 0) begin
          report_mismatch("unexpected transfer", 0, 0);
        end else begin
          e = expected_angles.pop_front();
          if (roll_o !== e.roll) report_mismatch("roll", roll_o, e.roll);
          if (pitch_o !== e.pitch) report_mismatch("pitch", pitch_o, e.pitch);
          if (yaw_o !== e.yaw) report_mismatch("yaw", yaw_o, e.yaw);
          if (sat_o !== e.sat) report_mismatch("pitch_saturated", sat_o, e.sat);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (cycle_cnt > CYCLE_MAX) begin
      $display("tb_quaternion_to_euler_core NOT OK");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic send_quat(logic signed [15:0] w, x, y, z, bit typed, euler_t ang);
    euler_t e;
    // drop valid only while the sender idles; back to back items keep it high
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    qw <= w; qx <= x; qy <= y; qz <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    e = predict_euler(w, x, y, z);
    if (typed && (e != ang)) report_mismatch("directed row vs predictor", 0, 1);
    expected_angles.push_back(e);
  endtask

  function automatic logic signed [15:0] rnd_comp();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'($urandom_range(8)) - 16'sd4;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_quat();
    real a, b, c, d, n;
    euler_t none;
    none = '{default: 0};
    if ($urandom_range(9) < 7) begin
      // well-formed: roughly unit length, random direction
      a = real'($urandom_range(2000)) - 1000.0;
      b = real'($urandom_range(2000)) - 1000.0;
      c = real'($urandom_range(2000)) - 1000.0;
      d = real'($urandom_range(2000)) - 1000.0;
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) begin a = 1.0; n = 1.0; end
      send_quat(16'($rtoi(a / n * 32767.0)), 16'($rtoi(b / n * 32767.0)),
                16'($rtoi(c / n * 32767.0)), 16'($rtoi(d / n * 32767.0)), 0, none);
    end else begin
      send_quat(rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(), 0, none);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk);
  endtask

  quat_row_t quat_table[] = '{
    // identity, zero and half turns about single axes
    '{16'sh7FFF, 16'sh0, 16'sh0, 16'sh0, 1, '{16'sd0, 15'sd0, 16'sd0, 1'b0}},
    '{16'sh0, 16'sh0, 16'sh0, 16'sh0, 0, '{default: 0}},
    '{16'sh8000, 16'sh0, 16'sh0, 16'sh0, 0, '{default: 0}},
    '{16'sh0, 16'sh7FFF, 16'sh0, 16'sh0, 0, '{default: 0}},
    '{16'sh0, 16'sh8000, 16'sh0, 16'sh0, 0, '{default: 0}},
    '{16'sh0, 16'sh0, 16'sh7FFF, 16'sh0, 0, '{default: 0}},
    '{16'sh0, 16'sh0, 16'sh0, 16'sh7FFF, 0, '{default: 0}},
    '{16'sh0, 16'sh0, 16'sh0, 16'sh8000, 0, '{default: 0}},
    // pitch argument beyond unity, both signs, then full-scale components
    '{16'sh7FFF, 16'sh0, 16'sh7FFF, 16'sh0, 0, '{default: 0}},
    '{16'sh7FFF, 16'sh0, 16'sh8000, 16'sh0, 0, '{default: 0}},
    '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0, '{default: 0}},
    '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, '{default: 0}},
    '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 0, '{default: 0}},
    // pitch exactly at unity, both signs: components are +-0x4000, so 2(wy - xz) = +-1 exactly
    '{16'sh4000, 16'sh4000, 16'sh4000, 16'shC000, 0, '{default: 0}},
    '{16'sh4000, 16'sh4000, 16'shC000, 16'sh4000, 0, '{default: 0}},
    // atan2 denominator near zero or negative, both numerator signs, then small and mixed rows
    '{16'sh5A82, 16'sh5A82, 16'sh0, 16'sh0, 0, '{default: 0}},
    '{16'sh0100, 16'sh7F00, 16'sh0, 16'sh0010, 0, '{default: 0}},
    '{16'sh0100, 16'sh8100, 16'sh0, 16'sh0010, 0, '{default: 0}},
    '{16'sh0010, 16'sh0, 16'sh0, 16'sh7FF0, 0, '{default: 0}},
    '{16'shFFF0, 16'sh0, 16'sh0, 16'sh7FF0, 0, '{default: 0}},
    '{16'sh0001, 16'shFFFF, 16'sh0001, 16'shFFFF, 0, '{default: 0}},
    '{16'sh5555, 16'shAAAA, 16'sh3333, 16'shCCCC, 0, '{default: 0}}
  };

  initial begin
    euler_t none;
    none = '{default: 0};
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    qw = '0; qx = '0; qy = '0; qz = '0;
    n_errors = 0;
    cycle_cnt = 0;
    send_idle_pct = 6;
    recv_idle_pct = 48;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (quat_table[i])
      send_quat(quat_table[i].w, quat_table[i].x, quat_table[i].y, quat_table[i].z,
                quat_table[i].typed, quat_table[i].ang);
    // hold off until the pipeline has drained
    drain_results();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) begin
        send_idle_pct = 48; recv_idle_pct = 6;
      end else if (i == 2 * N_RANDOM / 3) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      send_random_quat();
    end

    drain_results();
    repeat (LATENCY + 10) @(posedge clk);
    if (n_errors == 0 && expected_angles.size() == 0)
      $display("tb_quaternion_to_euler_core OK");
    else
      $display("tb_quaternion_to_euler_core NOT OK");
    $finish;
  end

endmodule

### sim.f
hw/rtl/qte_pkg.sv
hw/rtl/qte_front.sv
hw/rtl/qte_sqrt_stage.sv
hw/rtl/qte_prep.sv
hw/rtl/qte_cordic_stage.sv
hw/rtl/quaternion_to_euler_core.sv
tb/tb_quaternion_to_euler_core.sv
